>>> sv/ppmd_pkg.sv
// Package for the PPM frame decoder: sizes, codes, payload structs and enums.
// Used by ppmd_chan_store and ppm_frame_decoder; depends on nothing.
package ppmd_pkg;

    // channel slots per frame
    localparam int NUM_CHANNELS = 8;
    // bits of a slot number
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    // bits of a channel count, 0 to NUM_CHANNELS
    localparam int CNT_W  = $clog2(NUM_CHANNELS + 1);
    // results per read
    localparam int NUM_OUT = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
    // bits of the read issue counter, 0 to NUM_OUT
    localparam int IDX_W  = $clog2(NUM_OUT + 1);
    // slot store address: bank bit over slot number
    localparam int ADDR_W = CH_W + 1;

    // register reset values
    localparam logic [15:0] SYNC_THRESHOLD_RST = 16'd2500;
    localparam logic [31:0] LOST_DELAY_RST     = 32'd1000000;

    // register indexes
    localparam logic REG_SYNC_THRESHOLD = 1'b0;
    localparam logic REG_LOST_DELAY     = 1'b1;

    // input word opcodes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic        op;
        logic        level;
        logic [31:0] now_time;
    } ppmd_in_t;

    typedef struct packed {
        logic [2:0]  chan_index;
        logic [15:0] chan_value;
        logic [3:0]  chan_count;
        logic        lost;
        logic        last;
    } ppmd_out_t;

    // write request into the slot store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       data;
    } ppmd_wr_t;

    typedef enum logic [1:0] {
        PH_SYNC_RISE,
        PH_SYNC_FALL,
        PH_CH_RISE,
        PH_CH_FALL
    } ppmd_phase_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_READ
    } ppmd_seq_t;

endpackage

>>> sv/ppmd_chan_store.sv
// Two-bank channel slot store: one write port, one registered read port.
// Depends on ppmd_pkg.
module ppmd_chan_store (
    input  logic                          clk,
    input  ppmd_pkg::ppmd_wr_t            wr,
    input  logic                          rd_en,
    input  logic [ppmd_pkg::ADDR_W-1:0]   rd_addr,
    output logic [15:0]                   rd_data
);
    import ppmd_pkg::*;

    logic [15:0] mem [2**ADDR_W];
    logic [15:0] rd_data_reg;

    // write a captured slot
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read; hold data when not reading
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/ppm_frame_decoder.sv
// Top level of the PPM frame decoder: edge parser, failsafe check, read sequencer.
// Depends on ppmd_pkg and ppmd_chan_store.
//
// Usage: each input word is either a timestamped pin edge or a read request.
// Edges produce no result. A read first updates the failsafe flag, then
// streams one result word per channel (eight), the final one marked by last.
// The first word passes from the sequencer state through the store read
// register into the output register; with the receiver never stalling, the
// rest follow one per cycle, and item_stall is high while a read is in progress.
// The slot store read port (one read per cycle, registered data) sets this rate.
// Captured slots are written into one bank of the store while the other bank
// holds the published frame; a commit swaps banks, and slots at or above the
// published count read as zero, so no clearing pass is needed after reset.
// Reset returns the parser to waiting for a rising edge, publishes an empty
// frame with failsafe clear and loads default register values.
// When the receiver stalls, the current result word holds in the output
// register, at most one further slot read waits in the store read register,
// and the sequencer issues no more reads until the word is taken, so a stall
// lengthens the read.
module ppm_frame_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  ppmd_pkg::ppmd_in_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ppmd_pkg::ppmd_out_t  result,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_wdata
);
    import ppmd_pkg::*;

    // configuration
    logic [15:0] sync_thr_reg;
    logic [31:0] lost_delay_reg;

    // parser state
    ppmd_phase_t       phase_reg, phase_next;
    logic [31:0]       prev_edge_reg, prev_edge_next;
    logic [CNT_W-1:0]  cap_idx_reg, cap_idx_next;
    logic [31:0]       low_time_reg, low_time_next;

    // published frame
    logic              pub_bank_reg, pub_bank_next;
    logic [CNT_W-1:0]  pub_count_reg, pub_count_next;
    logic              failsafe_reg, failsafe_next;
    logic [31:0]       frame_time_reg, frame_time_next;

    // read sequencer
    ppmd_seq_t         seq_reg, seq_next;
    logic [IDX_W-1:0]  issue_idx_reg, issue_idx_next;
    logic [CH_W-1:0]   rd_idx_reg, rd_idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              out_valid_reg, out_valid_next;
    ppmd_out_t         out_data_reg, out_data_next;

    logic              accept;
    logic              edge_acc;
    logic              read_acc;
    logic              rising;
    logic [31:0]       span;
    logic              span_long;
    logic              load;
    logic              issue;
    logic [ADDR_W-1:0] rd_addr;
    logic [15:0]       rd_data;
    ppmd_wr_t          wr;
    logic [31:0]       since_frame;

    assign item_stall = (seq_reg != SEQ_IDLE);
    assign accept     = item_valid && !item_stall;
    assign edge_acc   = accept && (item.op == OP_EDGE);
    assign read_acc   = accept && (item.op == OP_READ);
    assign rising     = (item.level == 1'b1);
    assign span       = item.now_time - prev_edge_reg;
    assign span_long  = (span >= {16'd0, sync_thr_reg});
    assign since_frame = item.now_time - frame_time_reg;

    // parse edges, capture slots, commit frames, update failsafe on reads
    always_comb
    begin
        phase_next      = phase_reg;
        prev_edge_next  = prev_edge_reg;
        cap_idx_next    = cap_idx_reg;
        low_time_next   = low_time_reg;
        pub_bank_next   = pub_bank_reg;
        pub_count_next  = pub_count_reg;
        failsafe_next   = failsafe_reg;
        frame_time_next = frame_time_reg;
        wr.en           = 1'b0;
        wr.addr         = {~pub_bank_reg, cap_idx_reg[CH_W-1:0]};
        wr.data         = span[15:0] + low_time_reg[15:0];

        if (edge_acc)
        begin
            prev_edge_next = item.now_time;
            case (phase_reg)
                PH_SYNC_RISE:
                begin
                    if (rising)
                    begin
                        phase_next = PH_SYNC_FALL;
                    end
                end
                PH_SYNC_FALL:
                begin
                    if (rising || !span_long)
                    begin
                        phase_next     = PH_SYNC_RISE;
                        prev_edge_next = '0;
                        low_time_next  = '0;
                    end
                    else
                    begin
                        cap_idx_next = '0;
                        phase_next   = PH_CH_RISE;
                    end
                end
                PH_CH_RISE:
                begin
                    if (!rising)
                    begin
                        phase_next     = PH_SYNC_RISE;
                        prev_edge_next = '0;
                        low_time_next  = '0;
                    end
                    else
                    begin
                        low_time_next = span;
                        phase_next    = PH_CH_FALL;
                    end
                end
                PH_CH_FALL:
                begin
                    if (rising)
                    begin
                        phase_next     = PH_SYNC_RISE;
                        prev_edge_next = '0;
                        low_time_next  = '0;
                    end
                    else
                    begin
                        // sync gap ends the frame; otherwise store the slot, and a full frame also ends
                        if (!span_long && (cap_idx_reg < CNT_W'(NUM_CHANNELS)))
                        begin
                            wr.en        = 1'b1;
                            cap_idx_next = cap_idx_reg + 1'b1;
                        end
                        if (span_long || (cap_idx_next >= CNT_W'(NUM_CHANNELS)))
                        begin
                            // swap banks to publish the frame
                            pub_bank_next   = ~pub_bank_reg;
                            pub_count_next  = cap_idx_next;
                            failsafe_next   = 1'b0;
                            frame_time_next = item.now_time;
                            phase_next      = PH_SYNC_RISE;
                            prev_edge_next  = '0;
                            low_time_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_CH_RISE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC_RISE;
                end
            endcase
        end

        // on a read, raise failsafe when a non-empty frame is published and none has come for lost_delay ticks
        if (read_acc && (pub_count_reg != '0) && !failsafe_reg &&
            (since_frame >= lost_delay_reg))
        begin
            failsafe_next = 1'b1;
        end
    end

    // sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            SEQ_IDLE:
            begin
                if (read_acc)
                begin
                    seq_next = SEQ_READ;
                end
            end
            SEQ_READ:
            begin
                if (load && (rd_idx_reg == CH_W'(NUM_OUT - 1)))
                begin
                    seq_next = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // sequencer outputs: issue reads, load the output register
    always_comb
    begin
        load  = rd_pend_reg && (!out_valid_reg || !result_stall);
        issue = (seq_reg == SEQ_READ) && (issue_idx_reg < IDX_W'(NUM_OUT)) &&
                (!rd_pend_reg || load);
        rd_addr = {pub_bank_reg, CH_W'(issue_idx_reg)};

        issue_idx_next = issue_idx_reg;
        rd_idx_next    = rd_idx_reg;
        if (read_acc)
        begin
            issue_idx_next = '0;
        end
        else if (issue)
        begin
            issue_idx_next = issue_idx_reg + 1'b1;
            rd_idx_next    = CH_W'(issue_idx_reg);
        end
        rd_pend_next = issue || (rd_pend_reg && !load);

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next           = 1'b1;
            out_data_next.chan_index = 3'(rd_idx_reg);
            out_data_next.chan_value = (CNT_W'(rd_idx_reg) < pub_count_reg) ? rd_data : 16'd0;
            out_data_next.chan_count = 4'(pub_count_reg);
            out_data_next.lost       = failsafe_reg;
            out_data_next.last       = (rd_idx_reg == CH_W'(NUM_OUT - 1));
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    ppmd_chan_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_thr_reg   <= SYNC_THRESHOLD_RST;
            lost_delay_reg <= LOST_DELAY_RST;
            phase_reg      <= PH_SYNC_RISE;
            prev_edge_reg  <= '0;
            cap_idx_reg    <= '0;
            low_time_reg   <= '0;
            pub_bank_reg   <= 1'b0;
            pub_count_reg  <= '0;
            failsafe_reg   <= 1'b0;
            frame_time_reg <= '0;
            seq_reg        <= SEQ_IDLE;
            issue_idx_reg  <= '0;
            rd_idx_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_SYNC_THRESHOLD))
            begin
                sync_thr_reg <= cfg_wdata[15:0];
            end
            if (cfg_we && (cfg_index == REG_LOST_DELAY))
            begin
                lost_delay_reg <= cfg_wdata;
            end
            phase_reg      <= phase_next;
            prev_edge_reg  <= prev_edge_next;
            cap_idx_reg    <= cap_idx_next;
            low_time_reg   <= low_time_next;
            pub_bank_reg   <= pub_bank_next;
            pub_count_reg  <= pub_count_next;
            failsafe_reg   <= failsafe_next;
            frame_time_reg <= frame_time_next;
            seq_reg        <= seq_next;
            issue_idx_reg  <= issue_idx_next;
            rd_idx_reg     <= rd_idx_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // a store read is only in flight during a read sequence
    a_pend_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (seq_reg == SEQ_READ))
        else $error("slot read pending outside a read sequence");

    // published count never exceeds the slot count
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pub_count_reg <= CNT_W'(NUM_CHANNELS))
        else $error("published count out of range");

    // failsafe cannot rise while the published frame holds no channels
    a_no_frame_no_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (read_acc && (pub_count_reg == '0) && !failsafe_reg) |=> !failsafe_reg)
        else $error("failsafe raised without a published frame");

endmodule

>>> tb/ppmd_frame_checker.sv
// Frame checker for the PPM frame decoder: predicts channel reports and compares result words.
// Watches the input, result and register channels. Depends on ppmd_pkg.
module ppmd_frame_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  ppmd_pkg::ppmd_in_t   item,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  ppmd_pkg::ppmd_out_t  result,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_wdata,
    output int                   mismatches,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppmd_pkg::*;

    // register copies
    logic [15:0] sync_thr;
    logic [31:0] lost_after;

    // parser and frame state
    ppmd_phase_t phase;
    logic [31:0] prev_edge;
    logic [31:0] low_span;
    int          slot;
    logic [15:0] staged [NUM_CHANNELS];
    logic [15:0] shown  [NUM_CHANNELS];
    logic [3:0]  shown_count;
    logic        lost_flag;
    logic [31:0] frame_stamp;

    // channel reports still owed by the block, oldest first
    ppmd_out_t   due_reports [$];

    // drop back to waiting for a sync rising edge; the next edge counts from tick zero
    function automatic void rearm_parser();
        phase     = PH_SYNC_RISE;
        prev_edge = '0;
        low_span  = '0;
    endfunction

    // publish the captured slots, zero the rest, clear failsafe
    function automatic void publish_frame(input logic [31:0] stamp);
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            shown[i] = (i < slot) ? staged[i] : 16'd0;
        end
        shown_count = 4'(slot);
        lost_flag   = 1'b0;
        frame_stamp = stamp;
    endfunction

    // advance the parser by one pin edge
    function automatic void take_edge(input logic rising, input logic [31:0] stamp);
        logic [31:0] span;
        span      = stamp - prev_edge;
        prev_edge = stamp;
        case (phase)
            PH_SYNC_RISE:
            begin
                if (rising)
                    phase = PH_SYNC_FALL;
            end
            PH_SYNC_FALL:
            begin
                if (rising || span < sync_thr)
                    rearm_parser();
                else
                begin
                    slot  = 0;
                    phase = PH_CH_RISE;
                end
            end
            PH_CH_RISE:
            begin
                if (!rising)
                    rearm_parser();
                else
                begin
                    low_span = span;
                    phase    = PH_CH_FALL;
                end
            end
            default:
            begin
                if (rising)
                    rearm_parser();
                else if (span >= sync_thr)
                begin
                    publish_frame(stamp);
                    rearm_parser();
                end
                else
                begin
                    if (slot < NUM_CHANNELS)
                    begin
                        staged[slot] = span[15:0] + low_span[15:0];
                        slot++;
                    end
                    if (slot >= NUM_CHANNELS)
                    begin
                        publish_frame(stamp);
                        rearm_parser();
                    end
                    else
                        phase = PH_CH_RISE;
                end
            end
        endcase
    endfunction

    // raise failsafe if due, then queue one report per channel
    function automatic void queue_reports(input logic [31:0] stamp);
        logic [31:0] since;
        ppmd_out_t   rpt;
        since = stamp - frame_stamp;
        if (shown_count != 4'd0 && !lost_flag && since >= lost_after)
            lost_flag = 1'b1;
        for (int k = 0; k < NUM_OUT; k++)
        begin
            rpt.chan_index = 3'(k);
            rpt.chan_value = shown[k];
            rpt.chan_count = shown_count;
            rpt.lost       = lost_flag;
            rpt.last       = (k == NUM_OUT - 1);
            due_reports.push_back(rpt);
        end
    endfunction

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ppmd_out_t want;
        if (!rst_n)
        begin
            sync_thr   = SYNC_THRESHOLD_RST;
            lost_after = LOST_DELAY_RST;
            slot       = 0;
            rearm_parser();
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                staged[i] = '0;
                shown[i]  = '0;
            end
            shown_count = '0;
            lost_flag   = 1'b0;
            frame_stamp = '0;
            due_reports.delete();
            mismatches  = 0;
            pending     = 0;
        end
        else
        begin
            // track register writes
            if (cfg_we)
            begin
                if (cfg_index == REG_SYNC_THRESHOLD)
                    sync_thr = cfg_wdata[15:0];
                else
                    lost_after = cfg_wdata;
            end

            // predict from each accepted input word
            if (item_valid && !item_stall)
            begin
                if (item.op == OP_READ)
                    queue_reports(item.now_time);
                else
                    take_edge(item.level, item.now_time);
            end

            // compare each accepted result word with the oldest report due
            if (result_valid && !result_stall)
            begin
                if (due_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word expected none, got %0h", $time, result);
                end
                else
                begin
                    want = due_reports.pop_front();
                    compare_field("chan_index", want.chan_index, result.chan_index);
                    compare_field("chan_value", want.chan_value, result.chan_value);
                    compare_field("chan_count", want.chan_count, result.chan_count);
                    compare_field("lost",       want.lost,       result.lost);
                    compare_field("last",       want.last,       result.last);
                end
            end

            pending = due_reports.size();
        end
    end

endmodule

>>> tb/tb_ppm_frame_decoder.sv
// Testbench top for the PPM frame decoder: clock, reset, stimulus, receiver and verdict.
// Depends on ppmd_pkg, ppm_frame_decoder and ppmd_frame_checker.
module tb_ppm_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    ppmd_in_t    item;
    logic        result_valid;
    logic        result_stall;
    ppmd_out_t   result;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    int          mismatches;
    int          pending;

    // stimulus bookkeeping
    logic [31:0] pin_time;
    logic [31:0] commit_time;
    int          thr_now;
    logic [31:0] lost_now;
    int          items_sent;
    bit          quick;
    int          words_taken;
    bit          steady;

    ppm_frame_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    ppmd_frame_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // offer one input word after a random gap and hold it until taken
    task automatic put_word(input logic op, input logic lvl, input logic [31:0] stamp);
        ppmd_in_t w;
        int       gap;
        w.op       = op;
        w.level    = lvl;
        w.now_time = stamp;
        gap = quick ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    task automatic edge_at(input logic lvl, input logic [31:0] delta);
        pin_time = pin_time + delta;
        put_word(OP_EDGE, lvl, pin_time);
    endtask

    task automatic read_at(input logic [31:0] stamp);
        put_word(OP_READ, 1'($urandom_range(0, 1)), stamp);
    endtask

    // mostly pulse-sized spacing, now and then a jump across the whole counter
    function automatic logic [31:0] pick_gap();
        if ($urandom_range(0, 7) == 0)
            return 32'($urandom);
        return 32'($urandom_range(0, 40000));
    endfunction

    // build a frame of edges for the current threshold; a broken one is cut
    // short and ends with a repeated level
    task automatic send_frame(input bit broken);
        logic        lv [2*NUM_CHANNELS+4];
        logic [31:0] dt [2*NUM_CHANNELS+4];
        int          n;
        int          nch;
        int          stop;
        if (thr_now == 0)
            nch = 0;
        else if ($urandom_range(0, 2) == 0)
            nch = NUM_CHANNELS;
        else
            nch = $urandom_range(0, NUM_CHANNELS - 1);
        lv[0] = 1'b1;
        dt[0] = pick_gap();
        lv[1] = 1'b0;
        dt[1] = 32'(thr_now) + 32'($urandom_range(0, 3000));
        n = 2;
        for (int c = 0; c < nch; c++)
        begin
            lv[n]     = 1'b1;
            dt[n]     = pick_gap();
            lv[n + 1] = 1'b0;
            dt[n + 1] = 32'($urandom_range(0, thr_now - 1));
            n += 2;
        end
        // close a short frame with a long high time
        if (nch < NUM_CHANNELS)
        begin
            lv[n]     = 1'b1;
            dt[n]     = pick_gap();
            lv[n + 1] = 1'b0;
            dt[n + 1] = 32'(thr_now) + 32'($urandom_range(0, 5000));
            n += 2;
        end
        stop = broken ? $urandom_range(1, n - 1) : n;
        for (int i = 0; i < stop; i++)
            edge_at(lv[i], dt[i]);
        if (broken)
            edge_at(lv[stop - 1], pick_gap());
        else
            commit_time = pin_time;
    endtask

    // mix frames, reads, stray edges and broken frames until target words are sent
    task automatic random_traffic(input int target);
        int          pick;
        logic [31:0] stamp;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 7) == 0)
                quick = ~quick;
            pick = $urandom_range(0, 19);
            if (pick < 9)
                send_frame(1'b0);
            else if (pick < 15)
            begin
                case ($urandom_range(0, 2))
                    0:       stamp = pin_time + 32'($urandom_range(0, 5000));
                    1:       stamp = commit_time + lost_now + 32'($urandom_range(0, 2)) - 32'd1;
                    default: stamp = 32'($urandom);
                endcase
                read_at(stamp);
            end
            else if (pick < 18)
                edge_at(1'($urandom_range(0, 1)), pick_gap());
            else
                send_frame(1'b1);
        end
    endtask

    // hold off input until every report has come, then let the block settle
    task automatic settle();
        item_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_SYNC_THRESHOLD;
        cfg_wdata  <= '0;
        pin_time    = 32'($urandom);
        commit_time = '0;
        thr_now     = SYNC_THRESHOLD_RST;
        lost_now    = LOST_DELAY_RST;
        items_sent  = 0;
        quick       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // read before any frame
        read_at(pin_time);
        // falling edge while waiting for sync is ignored
        edge_at(1'b0, 32'd50);
        // sync high too short
        edge_at(1'b1, 32'd700);
        edge_at(1'b0, 32'd100);
        // rising edge where the sync falling edge is due
        edge_at(1'b1, 32'd900);
        edge_at(1'b1, 32'd40);
        // sync exactly at threshold, then falling where rising is due
        edge_at(1'b1, 32'd300);
        edge_at(1'b0, 32'd2500);
        edge_at(1'b0, 32'd60);
        // frame with no channels
        edge_at(1'b1, 32'd80);
        edge_at(1'b0, 32'd3000);
        edge_at(1'b1, 32'd400);
        edge_at(1'b0, 32'd2500);
        commit_time = pin_time;
        // empty frame never raises failsafe, even at the widest distance
        read_at(pin_time - 32'd1);
        // three channels: longest short high, 16-bit wrap, zero period
        edge_at(1'b1, 32'd500);
        edge_at(1'b0, 32'd2600);
        edge_at(1'b1, 32'd300);
        edge_at(1'b0, 32'd2499);
        edge_at(1'b1, 32'd70000);
        edge_at(1'b0, 32'd1000);
        edge_at(1'b1, 32'd0);
        edge_at(1'b0, 32'd0);
        edge_at(1'b1, 32'd500);
        edge_at(1'b0, 32'd4000);
        commit_time = pin_time;
        // failsafe boundary, then it stays set
        read_at(commit_time + lost_now - 32'd1);
        read_at(commit_time + lost_now);
        read_at(32'($urandom));

        // default registers, with one pause until all reports are in
        random_traffic(45);
        settle();
        random_traffic(57);

        // lowest register values
        settle();
        write_reg(REG_SYNC_THRESHOLD, {16'($urandom), 16'd0});
        write_reg(REG_LOST_DELAY, 32'd0);
        cfg_we  <= 1'b0;
        thr_now  = 0;
        lost_now = 32'd0;
        random_traffic(75);

        // highest register values
        settle();
        write_reg(REG_SYNC_THRESHOLD, {16'($urandom), 16'hFFFF});
        write_reg(REG_LOST_DELAY, 32'hFFFF_FFFF);
        cfg_we  <= 1'b0;
        thr_now  = 65535;
        lost_now = 32'hFFFF_FFFF;
        random_traffic(100);

        // random middle values
        settle();
        thr_now  = $urandom_range(300, 5000);
        lost_now = 32'($urandom_range(0, 300000));
        write_reg(REG_SYNC_THRESHOLD, {16'($urandom), 16'(thr_now)});
        write_reg(REG_LOST_DELAY, lost_now);
        cfg_we <= 1'b0;
        random_traffic(125);

        settle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // take result words after random stalls; one long hold fills the block
    initial
    begin : receiver
        int hold;
        result_stall <= 1'b0;
        words_taken = 0;
        steady      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                steady = ~steady;
            hold = steady ? 0 : $urandom_range(0, 13);
            if (words_taken == 44)
                hold = 120;
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            words_taken++;
        end
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
sv/ppmd_pkg.sv
sv/ppmd_chan_store.sv
sv/ppm_frame_decoder.sv
tb/ppmd_frame_checker.sv
tb/tb_ppm_frame_decoder.sv
